// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the framer.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while out of reset.
`define ZSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define ZSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/zsf_pkg.sv -----
// Package for the zlib stream framer: codes, queue entry type and header helper.
// No dependencies; every framer module imports it.
package zsf_pkg;

  // Input action codes. Code 3 is unused and is dropped by the front end.
  localparam logic [1:0] ACT_RAW    = 2'd0;
  localparam logic [1:0] ACT_PASS   = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LEVEL  = 2'd0;
  localparam logic [1:0] CFG_WINDOW = 2'd1;

  localparam logic [1:0] LEVEL_RESET  = 2'd2;
  localparam logic [2:0] WINDOW_RESET = 3'd7;

  localparam logic [3:0]  CMF_METHOD = 4'd8;
  localparam logic [16:0] ADLER_MOD  = 17'd65521;
  localparam logic [5:0]  HDR_CHECK  = 6'd31;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // What the back end has to emit for one item.
  typedef enum logic [1:0] {
    KIND_HDR_ONLY,
    KIND_PASS,
    KIND_END
  } kind_t;

  typedef struct packed {
    logic        hdr;
    kind_t       kind;
    logic [7:0]  cmf;
    logic [7:0]  flg;
    logic [7:0]  data;
    logic [31:0] chk;
  } entry_t;

  // Flag byte with the check bits that make CMF*256+FLG a multiple of 31.
  // Since 256 = 8 and 64 = 2 modulo 31, the remainder of the unpadded header
  // is 4*window + 2 + 2*level, which stays below 62, so one subtract reduces it.
  function automatic logic [7:0] header_flg(input logic [1:0] level,
                                            input logic [2:0] window);
    logic [5:0] x;
    logic [5:0] rem;
    logic [4:0] pad;
    x   = {1'b0, window, 2'b00} + 6'd2 + {3'b000, level, 1'b0};
    rem = (x >= HDR_CHECK) ? (x - HDR_CHECK) : x;
    pad = (rem == 6'd0) ? 5'd0 : 5'(HDR_CHECK - rem);
    return {level, 1'b0, pad};
  endfunction

endpackage

// ----- hw/rtl/zsf_front.sv -----
// Front end of the framer: configuration registers, header state, Adler-32 and
// classification of each input item into a queue entry. Uses zsf_pkg.
module zsf_front import zsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic [1:0]  level_r,  level_nxt;
  logic [2:0]  window_r, window_nxt;
  logic        hdr_sent_r, hdr_sent_nxt;
  logic [15:0] s1_r, s1_nxt;
  logic [15:0] s2_r, s2_nxt;
  logic        accept;
  logic [16:0] s1_sum, s1_red;
  logic [16:0] s2_sum, s2_red;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Configuration writes; unknown indexes are ignored.
  always_comb begin
    level_nxt  = level_r;
    window_nxt = window_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL:  level_nxt  = cfg_wdata[1:0];
        CFG_WINDOW: window_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Adler-32 step: both sums stay reduced, so one conditional subtract each.
  always_comb begin
    s1_sum = {1'b0, s1_r} + {9'd0, in_data_byte};
    s1_red = (s1_sum >= ADLER_MOD) ? (s1_sum - ADLER_MOD) : s1_sum;
    s2_sum = {1'b0, s2_r} + s1_red;
    s2_red = (s2_sum >= ADLER_MOD) ? (s2_sum - ADLER_MOD) : s2_sum;
  end

  // Stream state update for an accepted item.
  always_comb begin
    hdr_sent_nxt = hdr_sent_r;
    s1_nxt       = s1_r;
    s2_nxt       = s2_r;
    if (accept && (in_action != ACT_UNUSED)) begin
      hdr_sent_nxt = 1'b1;
      case (in_action)
        ACT_RAW: begin
          s1_nxt = s1_red[15:0];
          s2_nxt = s2_red[15:0];
        end
        ACT_END: begin
          hdr_sent_nxt = 1'b0;
          s1_nxt       = 16'd1;
          s2_nxt       = 16'd0;
        end
        default: ;
      endcase
    end
  end

  // Queue entry for the item; raw bytes after the header produce nothing.
  always_comb begin
    q_entry.hdr  = !hdr_sent_r;
    q_entry.cmf  = {1'b0, window_r, CMF_METHOD};
    q_entry.flg  = header_flg(level_r, window_r);
    q_entry.data = in_data_byte;
    q_entry.chk  = {s2_r, s1_r};
    case (in_action)
      ACT_PASS: q_entry.kind = KIND_PASS;
      ACT_END:  q_entry.kind = KIND_END;
      default:  q_entry.kind = KIND_HDR_ONLY;
    endcase
    q_push = accept && ((in_action == ACT_PASS) || (in_action == ACT_END) ||
                        ((in_action == ACT_RAW) && !hdr_sent_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= LEVEL_RESET;
      window_r   <= WINDOW_RESET;
      hdr_sent_r <= 1'b0;
      s1_r       <= 16'd1;
      s2_r       <= 16'd0;
    end else begin
      level_r    <= level_nxt;
      window_r   <= window_nxt;
      hdr_sent_r <= hdr_sent_nxt;
      s1_r       <= s1_nxt;
      s2_r       <= s2_nxt;
    end
  end

endmodule

// ----- hw/rtl/zsf_queue.sv -----
// Short register queue of entries between the front and back ends.
// Uses entry_t and the depth constants from zsf_pkg.
module zsf_queue import zsf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r,  count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- hw/rtl/zsf_back.sv -----
// Back end of the framer: steps through the result bytes of the queue head.
// Uses entry_t and kind_t from zsf_pkg.
module zsf_back import zsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_last_of_run,
  output logic       out_stream_end
);

  logic [2:0] step_r, step_nxt;
  logic [2:0] n_res;
  logic [2:0] body;
  logic [1:0] j;
  logic       last;
  logic       fire;

  // Number of results and the index within the body after the header.
  always_comb begin
    case (head.kind)
      KIND_PASS: body = 3'd1;
      KIND_END:  body = 3'd4;
      default:   body = 3'd0;
    endcase
    n_res = head.hdr ? body + 3'd2 : body;
    j     = head.hdr ? step_r[1:0] - 2'd2 : step_r[1:0];
    last  = (step_r == n_res - 3'd1);
  end

  // Byte for the current step: header first, then data or checksum big-endian.
  always_comb begin
    if (head.hdr && (step_r == 3'd0)) begin
      out_out_byte = head.cmf;
    end else if (head.hdr && (step_r == 3'd1)) begin
      out_out_byte = head.flg;
    end else if (head.kind == KIND_PASS) begin
      out_out_byte = head.data;
    end else begin
      case (j)
        2'd0:    out_out_byte = head.chk[31:24];
        2'd1:    out_out_byte = head.chk[23:16];
        2'd2:    out_out_byte = head.chk[15:8];
        default: out_out_byte = head.chk[7:0];
      endcase
    end
  end

  assign out_valid       = !q_empty;
  assign out_last_of_run = last;
  assign out_stream_end  = last && (head.kind == KIND_END);
  assign fire            = out_valid && out_ready;
  assign q_pop           = fire && last;

  // Step counter restarts for each entry.
  always_comb begin
    step_nxt = step_r;
    if (fire) begin
      step_nxt = last ? 3'd0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- hw/rtl/zlib_stream_framer_top.sv -----
// Top level of the zlib stream framer: front end, entry queue and back end.
// Depends on zsf_pkg, zsf_front, zsf_queue and zsf_back.
//
//   channel | signals                                        | direction
//   in      | in_valid, in_ready, in_action, in_data_byte    | input items
//   out     | out_valid, out_ready, out_out_byte, ...        | result items
//   cfg     | cfg_we, cfg_index, cfg_wdata                   | register writes
//
// An input item is accepted every cycle while the four-entry queue has room.
// Results leave at one per cycle, set by the back end sequencer, while out_ready is high; an item gives
// up to six results (two header bytes, then one data byte or four trailer bytes).
// The checksum is updated in the front end in the accepting cycle.
// A stalled output only holds back the input once the queue is full.
// Synchronous reset restores the register defaults and an empty queue.
module zlib_stream_framer_top import zsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_last_of_run,
  output logic       out_stream_end
);

  entry_t push_entry;
  entry_t head;
  logic   q_push, q_pop, q_full, q_empty;

  zsf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  zsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  zsf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_last_of_run (out_last_of_run),
    .out_stream_end  (out_stream_end)
  );

endmodule

// ----- hw/rtl/zsf_checker.sv -----
// Port-level checks for the zlib stream framer, bound to the top level.
// Depends on zsf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zsf_checker import zsf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_out_byte,
  input logic       out_last_of_run,
  input logic       out_stream_end
);

  // A stalled result keeps its byte.
  `ZSF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_out_byte), "stalled result changed")

  // The final trailer byte always closes its item's run.
  `ZSF_ASSERT(a_end_is_last, out_valid && out_stream_end |-> out_last_of_run, "stream end without last of run")

  // An item that always yields results shows one in the next cycle.
  `ZSF_ASSERT(a_result_follows, in_valid && in_ready && (in_action == ACT_PASS || in_action == ACT_END) |=> out_valid, "no result after a passing item")

  // Reset leaves no result pending.
  `ZSF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind zlib_stream_framer_top zsf_checker u_zsf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_out_byte    (out_out_byte),
  .out_last_of_run (out_last_of_run),
  .out_stream_end  (out_stream_end)
);

// ----- verif/zlib_stream_framer_top_test.sv -----
// Testbench for the zlib stream framer: random and directed items, checked against a predictor.
// Depends on zsf_pkg and zlib_stream_framer_top.
`timescale 1ns / 100ps

module zlib_stream_framer_top_test;
  import zsf_pkg::*;

  // Register indexes that the block must ignore.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 410;

  typedef struct {
    logic [1:0] action;
    logic [7:0] data;
  } stim_item_t;

  typedef struct {
    logic [7:0] value;
    logic       last_of_run;
    logic       stream_end;
  } frame_byte_t;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_COIN,
    PACE_SPARSE,
    PACE_RHYTHM
  } pace_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = '0;
  logic [7:0] in_data_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_last_of_run;
  logic       out_stream_end;

  // Items waiting to be offered, and framed bytes the block still owes.
  stim_item_t  pending_q[$];
  frame_byte_t framed_q[$];

  // Predictor state: checksum halves, header flag and register copies.
  logic [15:0] adler_lo = 16'd1;
  logic [15:0] adler_hi = 16'd0;
  logic        hdr_sent = 1'b0;
  logic [1:0]  level_cfg = LEVEL_RESET;
  logic [2:0]  window_cfg = WINDOW_RESET;

  int items_queued = 0;
  int items_pushed = 0;
  int accepted_items = 0;
  int mismatches = 0;
  int cycle_count = 0;

  zlib_stream_framer_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_last_of_run(out_last_of_run),
    .out_stream_end (out_stream_end)
  );

  always #5 clk = ~clk;

  // Work out the framed bytes that one accepted item causes and queue them.
  task automatic predict_frame(input logic [1:0] act, input logic [7:0] data);
    frame_byte_t run[$];
    frame_byte_t fb;
    logic [7:0]  cmf;
    logic [7:0]  flg;
    logic [16:0] s1;
    logic [16:0] s2;
    int          rem;
    if (act == ACT_UNUSED) return;
    fb.last_of_run = 1'b0;
    fb.stream_end = 1'b0;
    if (!hdr_sent) begin
      cmf = {1'b0, window_cfg, CMF_METHOD};
      flg = {level_cfg, 6'd0};
      rem = {cmf, flg} % HDR_CHECK;
      if (rem != 0) flg = flg | 8'(HDR_CHECK - rem);
      fb.value = cmf;
      run.push_back(fb);
      fb.value = flg;
      run.push_back(fb);
      hdr_sent = 1'b1;
    end
    case (act)
      ACT_RAW: begin
        s1 = {1'b0, adler_lo};
        s2 = {1'b0, adler_hi};
        if (s1 >= ADLER_MOD) s1 = s1 - ADLER_MOD;
        if (s2 >= ADLER_MOD) s2 = s2 - ADLER_MOD;
        s1 = s1 + data;
        if (s1 >= ADLER_MOD) s1 = s1 - ADLER_MOD;
        s2 = s2 + s1;
        if (s2 >= ADLER_MOD) s2 = s2 - ADLER_MOD;
        adler_lo = s1[15:0];
        adler_hi = s2[15:0];
      end
      ACT_PASS: begin
        fb.value = data;
        run.push_back(fb);
      end
      default: begin
        // Trailer is the checksum, most significant byte first.
        fb.value = adler_hi[15:8];
        run.push_back(fb);
        fb.value = adler_hi[7:0];
        run.push_back(fb);
        fb.value = adler_lo[15:8];
        run.push_back(fb);
        fb.value = adler_lo[7:0];
        fb.stream_end = 1'b1;
        run.push_back(fb);
        adler_lo = 16'd1;
        adler_hi = 16'd0;
        hdr_sent = 1'b0;
      end
    endcase
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) framed_q.push_back(run[i]);
  endtask

  task automatic push_item(input logic [1:0] act, input logic [7:0] data);
    stim_item_t it;
    it.action = act;
    it.data = data;
    pending_q.push_back(it);
    items_pushed++;
    if (act != ACT_UNUSED) items_queued++;
  endtask

  // Wait until every item is taken and every framed byte has come out.
  task automatic wait_drained();
    while (accepted_items != items_pushed || framed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LEVEL:  level_cfg = val[1:0];
      CFG_WINDOW: window_cfg = val;
      default: ;
    endcase
  endtask

  // Driver: offers queued items in bursts with gaps between them.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drive_items
    stim_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_action <= '0;
      in_data_byte <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_frame(in_action, in_data_byte);
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          in_valid <= 1'b1;
          in_action <= it.action;
          in_data_byte <= it.data;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver pacing: shifting stall patterns, plus long hold-offs that fill the block.
  pace_mode_t pace_mode = PACE_FREE;
  int pace_left = 0;
  int pace_tick = 0;
  int hold_left = 0;
  int hold_mark = 60;

  always @(posedge clk) begin : pace_results
    logic rdy_next;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        rdy_next = 1'b0;
      end else if (accepted_items >= hold_mark) begin
        hold_left = HOLD_CYCLES;
        hold_mark = hold_mark + 200;
        rdy_next = 1'b0;
      end else begin
        if (pace_left == 0) begin
          pace_mode = pace_mode_t'($urandom_range(0, 3));
          pace_left = $urandom_range(8, 60);
        end else begin
          pace_left--;
        end
        pace_tick++;
        case (pace_mode)
          PACE_FREE:   rdy_next = 1'b1;
          PACE_COIN:   rdy_next = 1'($urandom_range(0, 1));
          PACE_SPARSE: rdy_next = ($urandom_range(0, 3) == 0);
          default:     rdy_next = (pace_tick % 3 != 0);
        endcase
      end
      out_ready <= rdy_next;
    end
  end

  // Monitor: each framed byte must match the oldest one predicted.
  always @(posedge clk) begin : check_results
    frame_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (framed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: byte %02h last %0b end %0b",
                   out_out_byte, out_last_of_run, out_stream_end);
      end else begin
        want = framed_q.pop_front();
        if (want.value !== out_out_byte || want.last_of_run !== out_last_of_run ||
            want.stream_end !== out_stream_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %02h last %0b end %0b, got %02h %0b %0b",
                     want.value, want.last_of_run, want.stream_end,
                     out_out_byte, out_last_of_run, out_stream_end);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed streams, then random phases with new settings.
  initial begin : main_seq
    int target;
    int phase;
    int n_streams;
    int body_len;
    int pick;
    logic [2:0] lvl_val;
    logic [2:0] win_val;
    logic leave_open;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty stream, ignored code, extremes of the byte.
    push_item(ACT_END, 8'hff);
    push_item(ACT_UNUSED, 8'h00);
    push_item(ACT_RAW, 8'h00);
    push_item(ACT_RAW, 8'hff);
    push_item(ACT_PASS, 8'h00);
    push_item(ACT_PASS, 8'hff);
    push_item(ACT_UNUSED, 8'haa);
    push_item(ACT_RAW, 8'h80);
    push_item(ACT_END, 8'h00);
    push_item(ACT_PASS, 8'h5a);
    push_item(ACT_END, 8'h5a);
    push_item(ACT_RAW, 8'h01);
    push_item(ACT_END, 8'ha5);
    wait_drained();

    // Lowest settings, and a write to an index that does not exist.
    write_reg(CFG_LEVEL, 3'd0);
    write_reg(CFG_WINDOW, 3'd0);
    write_reg(CFG_SPARE_A, 3'd5);
    push_item(ACT_PASS, 8'hff);
    push_item(ACT_END, 8'h00);
    wait_drained();

    // Highest settings; the stream is left open across the next write.
    write_reg(CFG_LEVEL, 3'd7);
    write_reg(CFG_WINDOW, 3'd7);
    write_reg(CFG_SPARE_B, 3'd2);
    push_item(ACT_END, 8'h00);
    push_item(ACT_RAW, 8'h7f);
    wait_drained();

    // A write in the middle of a stream only shows at the following header.
    write_reg(CFG_LEVEL, 3'd1);
    write_reg(CFG_WINDOW, 3'd4);
    push_item(ACT_RAW, 8'h10);
    push_item(ACT_PASS, 8'h20);
    push_item(ACT_END, 8'h30);
    push_item(ACT_END, 8'h00);
    wait_drained();

    // Random phases, each with its own settings.
    target = items_queued + RANDOM_ITEMS;
    phase = 0;
    while (items_queued < target) begin
      case (phase)
        0: begin
          lvl_val = 3'd0;
          win_val = 3'd0;
        end
        1: begin
          lvl_val = 3'd3;
          win_val = 3'd7;
        end
        default: begin
          lvl_val = 3'($urandom_range(0, 7));
          win_val = 3'($urandom_range(0, 7));
        end
      endcase
      write_reg(CFG_LEVEL, lvl_val);
      write_reg(CFG_WINDOW, win_val);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  3'($urandom_range(0, 7)));

      if (phase == 2) begin
        // One long run of large bytes, so that both sums wrap past the modulus.
        repeat (270) push_item(ACT_RAW, 8'($urandom_range(245, 255)));
        push_item(ACT_END, 8'($urandom_range(0, 255)));
      end else begin
        n_streams = $urandom_range(2, 6);
        for (int s = 0; s < n_streams; s++) begin
          body_len = $urandom_range(0, 10);
          for (int b = 0; b < body_len; b++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) push_item(ACT_RAW, 8'($urandom_range(0, 255)));
            else if (pick < 90) push_item(ACT_PASS, 8'($urandom_range(0, 255)));
            else if (pick < 95) push_item(ACT_UNUSED, 8'($urandom_range(0, 255)));
            else push_item(ACT_END, 8'($urandom_range(0, 255)));
          end
          leave_open = (s == n_streams - 1) && ($urandom_range(0, 2) == 0);
          if (!leave_open) push_item(ACT_END, 8'($urandom_range(0, 255)));
        end
      end
      wait_drained();
      phase++;
    end

    if (mismatches == 0 && framed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/zsf_pkg.sv
hw/rtl/zsf_front.sv
hw/rtl/zsf_queue.sv
hw/rtl/zsf_back.sv
hw/rtl/zlib_stream_framer_top.sv
hw/rtl/zsf_checker.sv
verif/zlib_stream_framer_top_test.sv
